FILE: rtl/gauge_link_row_reconstruct_core_macros.svh
// assertion macros used by the gauge link row reconstruct back end
`ifndef GAUGE_LINK_ROW_RECONSTRUCT_CORE_MACROS_SVH
`define GAUGE_LINK_ROW_RECONSTRUCT_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define GLRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define GLRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/glrc_pkg.sv
// shared constants and types of the gauge link row reconstruct block
package glrc_pkg;

    // lattice extent limits
    localparam int MAX_EXTENT = 64;
    localparam int EXT_CAP    = (MAX_EXTENT < 64) ? MAX_EXTENT : 64;

    // fixed point and queue defaults
    localparam int FRAC_BITS   = 30;
    localparam int QUEUE_DEPTH = 4;

    // configuration register indexes
    localparam logic [1:0] CFG_EXTENT_X    = 2'd0;
    localparam logic [1:0] CFG_EXTENT_Y    = 2'd1;
    localparam logic [1:0] CFG_EXTENT_Z    = 2'd2;
    localparam logic [1:0] CFG_ROWS_STORED = 2'd3;

    // configuration reset values
    localparam logic [6:0] EXTENT_RESET = 7'd8;
    localparam logic [1:0] ROWS_RESET   = 2'd2;
    localparam logic [1:0] ROWS_FULL    = 2'd3;

    // row index of the rebuilt row
    localparam logic [1:0] ROW_THIRD = 2'd2;

    // one classified element passed from front to back
    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic [5:0]         x;
        logic [5:0]         y;
        logic [5:0]         z;
        logic [1:0]         dir;
        logic [1:0]         row;
        logic [1:0]         col;
        logic               save;
        logic [2:0]         save_idx;
        logic               recon;
        logic               end_z;
    } t_entry;

endpackage

FILE: rtl/glrc_front.sv
// front end: configuration, lattice position tracking and element classification
module glrc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [6:0]           i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic signed [31:0]   i_elem_re,
    input  logic signed [31:0]   i_elem_im,
    output logic                 o_push,
    input  logic                 i_q_ready,
    output glrc_pkg::t_entry     o_entry
);

    logic [6:0] r_ext_x, r_ext_y, r_ext_z;
    logic [1:0] r_rows;
    logic [1:0] r_col, r_row, r_dir;
    logic [5:0] r_x, r_y, r_z;
    logic [1:0] n_col, n_row, n_dir;
    logic [5:0] n_x, n_y, n_z;

    logic       three_rows;
    logic       end_row, end_dir, end_site, end_x, end_y, end_z;
    logic [3:0] flat_idx;
    logic       accept;

    // last coordinate along an axis, with out-of-range extents clamped
    function automatic logic [5:0] last_pos(input logic [6:0] e);
        if (e == 7'd0) begin
            return 6'd0;
        end else if (e > 7'(glrc_pkg::EXT_CAP)) begin
            return 6'(glrc_pkg::EXT_CAP - 1);
        end else begin
            return 6'(e - 7'd1);
        end
    endfunction

    assign accept     = i_in_valid && i_q_ready;
    assign o_in_ready = i_q_ready;
    assign o_push     = accept;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext_x <= glrc_pkg::EXTENT_RESET;
            r_ext_y <= glrc_pkg::EXTENT_RESET;
            r_ext_z <= glrc_pkg::EXTENT_RESET;
            r_rows  <= glrc_pkg::ROWS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                glrc_pkg::CFG_EXTENT_X:    r_ext_x <= i_cfg_data;
                glrc_pkg::CFG_EXTENT_Y:    r_ext_y <= i_cfg_data;
                glrc_pkg::CFG_EXTENT_Z:    r_ext_z <= i_cfg_data;
                glrc_pkg::CFG_ROWS_STORED: r_rows  <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    // span ends at the current position
    assign three_rows = (r_rows == glrc_pkg::ROWS_FULL);
    assign end_row    = (r_col >= 2'd2);
    assign end_dir    = end_row && (r_row >= (three_rows ? 2'd2 : 2'd1));
    assign end_site   = end_dir && (r_dir >= 2'd3);
    assign end_x      = end_site && (r_x >= last_pos(r_ext_x));
    assign end_y      = end_x && (r_y >= last_pos(r_ext_y));
    assign end_z      = end_y && (r_z >= last_pos(r_ext_z));
    assign flat_idx   = 4'(r_row) * 4'd3 + 4'(r_col);

    // classified element towards the queue
    always_comb begin
        o_entry.re       = i_elem_re;
        o_entry.im       = i_elem_im;
        o_entry.x        = r_x;
        o_entry.y        = r_y;
        o_entry.z        = r_z;
        o_entry.dir      = r_dir + 2'd1;
        o_entry.row      = r_row;
        o_entry.col      = r_col;
        o_entry.save     = (r_row < 2'd2) && (flat_idx < 4'd5);
        o_entry.save_idx = flat_idx[2:0];
        o_entry.recon    = !three_rows && end_dir;
        o_entry.end_z    = end_z;
    end

    // next position
    always_comb begin
        n_col = end_row ? 2'd0 : r_col + 2'd1;
        n_row = r_row;
        n_dir = r_dir;
        n_x   = r_x;
        n_y   = r_y;
        n_z   = r_z;
        if (end_row) begin
            n_row = end_dir ? 2'd0 : r_row + 2'd1;
        end
        if (end_dir) begin
            n_dir = end_site ? 2'd0 : r_dir + 2'd1;
        end
        if (end_site) begin
            n_x = end_x ? 6'd0 : r_x + 6'd1;
        end
        if (end_x) begin
            n_y = end_y ? 6'd0 : r_y + 6'd1;
        end
        if (end_y) begin
            n_z = end_z ? 6'd0 : r_z + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= 2'd0;
            r_row <= 2'd0;
            r_dir <= 2'd0;
            r_x   <= 6'd0;
            r_y   <= 6'd0;
            r_z   <= 6'd0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
            r_dir <= n_dir;
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
        end
    end

endmodule

FILE: rtl/glrc_queue.sv
// short first-in first-out queue between the front and back ends
module glrc_queue #(
    parameter int DEPTH = glrc_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  glrc_pkg::t_entry i_data,
    output logic             o_ready,
    input  logic             i_pop,
    output logic             o_valid,
    output glrc_pkg::t_entry o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    glrc_pkg::t_entry r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_count;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/glrc_back.sv
// back end: saved rows, third-row cross product pipeline and output register
`include "gauge_link_row_reconstruct_core_macros.svh"

module glrc_back #(
    parameter int FRAC_BITS = glrc_pkg::FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  glrc_pkg::t_entry   i_q_data,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_out_re,
    output logic signed [31:0] o_out_im,
    output logic [5:0]         o_site_x,
    output logic [5:0]         o_site_y,
    output logic [5:0]         o_site_z,
    output logic [1:0]         o_direction,
    output logic [1:0]         o_row,
    output logic [1:0]         o_col,
    output logic               o_reconstructed,
    output logic               o_last_of_run,
    output logic               o_last_of_slice
);

    localparam int PW = 64 - FRAC_BITS;
    localparam int SW = PW + 3;

    // operations issued per element
    localparam logic [1:0] OP_PASS = 2'd0;
    localparam logic [1:0] OP_COL0 = 2'd1;
    localparam logic [1:0] OP_COL1 = 2'd2;
    localparam logic [1:0] OP_COL2 = 2'd3;

    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
    } t_cplx;

    typedef struct packed {
        logic [5:0] x;
        logic [5:0] y;
        logic [5:0] z;
        logic [1:0] dir;
        logic [1:0] row;
        logic [1:0] col;
        logic       rec;
        logic       last_run;
        logic       last_slice;
    } t_tag;

    glrc_pkg::t_entry r_cur;
    logic             r_cur_valid;
    logic [1:0]       r_op;
    logic [63:0]      r_saved [5];

    logic             en, issue, issue_last, pop;
    t_cplx            u00, u01, u02, u10, u11, u12;
    t_cplx            p, q, r, s;
    t_tag             issue_tag;
    logic signed [63:0] w_prod [8];
    logic signed [63:0] w_trunc [8];

    logic               r1_valid, r1_compute;
    t_tag               r1_tag;
    t_cplx              r1_pass;
    logic signed [PW-1:0] r1_prod [8];

    logic signed [SW-1:0] w_ext [8];
    logic signed [SW-1:0] w_sum_re, w_sum_im;

    logic               r2_valid;
    t_tag               r2_tag;
    logic signed [31:0] r2_re, r2_im;

    logic               r_out_valid;
    t_tag               r_out_tag;
    logic signed [31:0] r_out_re, r_out_im;

    // clamp to the signed 32-bit range
    function automatic logic [31:0] sat32(input logic signed [SW-1:0] v);
        logic [SW-32:0] top;
        top = v[SW-1:31];
        if ((&top) || !(|top)) begin
            return v[31:0];
        end else if (v[SW-1]) begin
            return 32'h8000_0000;
        end else begin
            return 32'h7fff_ffff;
        end
    endfunction

    // whole pipeline moves when the output register is free
    assign en         = !r_out_valid || i_out_ready;
    assign issue      = en && r_cur_valid;
    assign issue_last = !r_cur.recon || (r_op == OP_COL2);
    assign pop        = i_q_valid && (!r_cur_valid || (issue && issue_last));
    assign o_q_pop    = pop;

    // current element and op sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_op        <= OP_PASS;
        end else if (pop) begin
            r_cur_valid <= 1'b1;
            r_op        <= OP_PASS;
        end else if (issue && issue_last) begin
            r_cur_valid <= 1'b0;
        end else if (issue) begin
            r_op <= r_op + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cur <= i_q_data;
        end
    end

    // first five elements of the first two rows kept for the rebuild, written as they issue
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 5; i++) begin
            if (issue && (r_op == OP_PASS) && r_cur.save && (r_cur.save_idx == 3'(i))) begin
                r_saved[i] <= {r_cur.im, r_cur.re};
            end
        end
    end

    // operand selection per rebuilt column
    always_comb begin
        u00 = '{re: r_saved[0][31:0], im: r_saved[0][63:32]};
        u01 = '{re: r_saved[1][31:0], im: r_saved[1][63:32]};
        u02 = '{re: r_saved[2][31:0], im: r_saved[2][63:32]};
        u10 = '{re: r_saved[3][31:0], im: r_saved[3][63:32]};
        u11 = '{re: r_saved[4][31:0], im: r_saved[4][63:32]};
        u12 = '{re: r_cur.re, im: r_cur.im};
        case (r_op)
            OP_COL0: begin
                p = u01; q = u12; r = u11; s = u02;
            end
            OP_COL1: begin
                p = u10; q = u02; r = u00; s = u12;
            end
            default: begin
                p = u00; q = u11; r = u10; s = u01;
            end
        endcase
    end

    // tags of the issued result
    always_comb begin
        issue_tag.x   = r_cur.x;
        issue_tag.y   = r_cur.y;
        issue_tag.z   = r_cur.z;
        issue_tag.dir = r_cur.dir;
        if (r_op == OP_PASS) begin
            issue_tag.row        = r_cur.row;
            issue_tag.col        = r_cur.col;
            issue_tag.rec        = 1'b0;
            issue_tag.last_run   = !r_cur.recon;
            issue_tag.last_slice = !r_cur.recon && r_cur.end_z;
        end else begin
            issue_tag.row        = glrc_pkg::ROW_THIRD;
            issue_tag.col        = r_op - 2'd1;
            issue_tag.rec        = 1'b1;
            issue_tag.last_run   = (r_op == OP_COL2);
            issue_tag.last_slice = (r_op == OP_COL2) && r_cur.end_z;
        end
    end

    // eight real products, floored by the fraction width
    always_comb begin
        w_prod[0] = $signed(p.re) * $signed(q.re);
        w_prod[1] = $signed(p.im) * $signed(q.im);
        w_prod[2] = $signed(r.re) * $signed(s.re);
        w_prod[3] = $signed(r.im) * $signed(s.im);
        w_prod[4] = $signed(p.re) * $signed(q.im);
        w_prod[5] = $signed(p.im) * $signed(q.re);
        w_prod[6] = $signed(r.re) * $signed(s.im);
        w_prod[7] = $signed(r.im) * $signed(s.re);
        for (int i = 0; i < 8; i++) begin
            w_trunc[i] = w_prod[i] >>> FRAC_BITS;
        end
    end

    // stage one: products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_tag     <= issue_tag;
            r1_compute <= (r_op != OP_PASS);
            r1_pass    <= u12;
            for (int i = 0; i < 8; i++) begin
                r1_prod[i] <= w_trunc[i][PW-1:0];
            end
        end
    end

    // conjugated difference of the two complex products
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_ext[i] = {{3{r1_prod[i][PW-1]}}, r1_prod[i]};
        end
        w_sum_re = (w_ext[0] - w_ext[1]) - (w_ext[2] - w_ext[3]);
        w_sum_im = (w_ext[6] + w_ext[7]) - (w_ext[4] + w_ext[5]);
    end

    // stage two: sums and saturation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_tag <= r1_tag;
            r2_re  <= r1_compute ? sat32(w_sum_re) : r1_pass.re;
            r2_im  <= r1_compute ? sat32(w_sum_im) : r1_pass.im;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_tag <= r2_tag;
            r_out_re  <= r2_re;
            r_out_im  <= r2_im;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_re        = r_out_re;
    assign o_out_im        = r_out_im;
    assign o_site_x        = r_out_tag.x;
    assign o_site_y        = r_out_tag.y;
    assign o_site_z        = r_out_tag.z;
    assign o_direction     = r_out_tag.dir;
    assign o_row           = r_out_tag.row;
    assign o_col           = r_out_tag.col;
    assign o_reconstructed = r_out_tag.rec;
    assign o_last_of_run   = r_out_tag.last_run;
    assign o_last_of_slice = r_out_tag.last_slice;

    // checks
    `GLRC_ASSERT_IMP(a_rebuilt_row, i_clk, i_rst_n, r_out_valid && r_out_tag.rec, r_out_tag.row == glrc_pkg::ROW_THIRD, "rebuilt element not on the third row")
    `GLRC_ASSERT_IMP(a_slice_ends_run, i_clk, i_rst_n, r_out_valid && r_out_tag.last_slice, r_out_tag.last_run, "slice end without run end")
    `GLRC_ASSERT_NXT(a_pop_loads, i_clk, i_rst_n, pop, r_cur_valid && (r_op == OP_PASS), "popped element not loaded for issue")

endmodule

FILE: rtl/gauge_link_row_reconstruct_core.sv
// path: queue, current-element register, stage one, stage two and the output register
// throughput: one result per cycle from the output register while i_out_ready is high;
//   with two rows stored a direction's sixth element gives four results, so six elements
//   give nine results; with three rows stored one element per cycle when not stalled
// reset: counters clear, extents return to 8 and rows stored to 2; saved rows undefined
module gauge_link_row_reconstruct_core #(
    parameter int FRAC_BITS   = glrc_pkg::FRAC_BITS,
    parameter int QUEUE_DEPTH = glrc_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [6:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_elem_re,
    input  logic signed [31:0] i_elem_im,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_out_re,
    output logic signed [31:0] o_out_im,
    output logic [5:0]         o_site_x,
    output logic [5:0]         o_site_y,
    output logic [5:0]         o_site_z,
    output logic [1:0]         o_direction,
    output logic [1:0]         o_row,
    output logic [1:0]         o_col,
    output logic               o_reconstructed,
    output logic               o_last_of_run,
    output logic               o_last_of_slice
);

    logic             push, q_ready, q_valid, q_pop;
    glrc_pkg::t_entry front_entry, q_entry;

    // classification and position tracking
    glrc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_elem_re  (i_elem_re),
        .i_elem_im  (i_elem_im),
        .o_push     (push),
        .i_q_ready  (q_ready),
        .o_entry    (front_entry)
    );

    // decoupling queue
    glrc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_entry),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_entry)
    );

    // rebuild and output
    glrc_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_data        (q_entry),
        .o_q_pop         (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_re        (o_out_re),
        .o_out_im        (o_out_im),
        .o_site_x        (o_site_x),
        .o_site_y        (o_site_y),
        .o_site_z        (o_site_z),
        .o_direction     (o_direction),
        .o_row           (o_row),
        .o_col           (o_col),
        .o_reconstructed (o_reconstructed),
        .o_last_of_run   (o_last_of_run),
        .o_last_of_slice (o_last_of_slice)
    );

endmodule

FILE: tb/tb_gauge_link_row_reconstruct_core.sv
`timescale 1ns / 100ps
// self-checking testbench for the gauge link row reconstruct core
module tb_gauge_link_row_reconstruct_core;
    import glrc_pkg::*;

    // one emitted matrix element with its tags
    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic [5:0]         x;
        logic [5:0]         y;
        logic [5:0]         z;
        logic [1:0]         dir;
        logic [1:0]         row;
        logic [1:0]         col;
        logic               rec;
        logic               lrun;
        logic               lslice;
    } link_elem_t;

    // wide complex value for the third-row arithmetic
    typedef struct {
        longint re;
        longint im;
    } cval_t;

    // opening stimulus: either a register write or an element, maybe with a typed result
    typedef struct {
        bit                 is_reg;
        logic [1:0]         reg_idx;
        logic [6:0]         reg_val;
        logic signed [31:0] re;
        logic signed [31:0] im;
        bit                 known;
        link_elem_t         want;
    } opening_row_t;

    localparam longint Q_MAX = 64'sh7FFF_FFFF;
    localparam longint Q_MIN = -64'sh8000_0000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [6:0]         i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic signed [31:0] i_elem_re;
    logic signed [31:0] i_elem_im;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [31:0] o_out_re;
    logic signed [31:0] o_out_im;
    logic [5:0]         o_site_x;
    logic [5:0]         o_site_y;
    logic [5:0]         o_site_z;
    logic [1:0]         o_direction;
    logic [1:0]         o_row;
    logic [1:0]         o_col;
    logic               o_reconstructed;
    logic               o_last_of_run;
    logic               o_last_of_slice;

    // predictor copy of the registers and counters
    logic [6:0]   ext_x_cfg;
    logic [6:0]   ext_y_cfg;
    logic [6:0]   ext_z_cfg;
    logic [1:0]   rows_cfg;
    int           col_at;
    int           row_at;
    int           dir_at;
    int           site_x;
    int           site_y;
    int           site_z;
    cval_t        held_elems [5];

    link_elem_t   due_elements [$];
    opening_row_t opening [$];
    int           err_count;
    int           send_idle_pct;
    int           recv_idle_pct;

    gauge_link_row_reconstruct_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_elem_re       (i_elem_re),
        .i_elem_im       (i_elem_im),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_re        (o_out_re),
        .o_out_im        (o_out_im),
        .o_site_x        (o_site_x),
        .o_site_y        (o_site_y),
        .o_site_z        (o_site_z),
        .o_direction     (o_direction),
        .o_row           (o_row),
        .o_col           (o_col),
        .o_reconstructed (o_reconstructed),
        .o_last_of_run   (o_last_of_run),
        .o_last_of_slice (o_last_of_slice)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // truncating fixed point product, rounds toward minus infinity
    function automatic longint qmul(longint a, longint b);
        longint p;
        p = a * b;
        return p >>> FRAC_BITS;
    endfunction

    function automatic logic [31:0] clamp_q(longint v);
        if (v > Q_MAX) return 32'h7FFF_FFFF;
        if (v < Q_MIN) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // extent as the block uses it: zero acts as one, large values hit the cap
    function automatic int span(logic [6:0] e);
        if (e == 7'd0) return 1;
        if (e > EXT_CAP) return EXT_CAP;
        return e;
    endfunction

    // conj(p*q - r*s) on truncated products, not yet saturated
    function automatic cval_t conj_cross(cval_t p, cval_t q, cval_t r, cval_t s);
        cval_t c;
        c.re = (qmul(p.re, q.re) - qmul(p.im, q.im)) - (qmul(r.re, s.re) - qmul(r.im, s.im));
        c.im = -((qmul(p.re, q.im) + qmul(p.im, q.re)) - (qmul(r.re, s.im) + qmul(r.im, s.re)));
        return c;
    endfunction

    function automatic link_elem_t make_elem(longint re, longint im, int row, int col,
                                             bit rec, bit lrun, bit lslice, int dir);
        link_elem_t e;
        e.re     = clamp_q(re);
        e.im     = clamp_q(im);
        e.x      = site_x[5:0];
        e.y      = site_y[5:0];
        e.z      = site_z[5:0];
        e.dir    = dir[1:0];
        e.row    = row[1:0];
        e.col    = col[1:0];
        e.rec    = rec;
        e.lrun   = lrun;
        e.lslice = lslice;
        return e;
    endfunction

    function automatic string show_elem(link_elem_t e);
        return $sformatf("re=%h im=%h site=%0d/%0d/%0d dir=%0d row=%0d col=%0d rec=%b run=%b slice=%b",
                         e.re, e.im, e.x, e.y, e.z, e.dir, e.row, e.col, e.rec, e.lrun, e.lslice);
    endfunction

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= 10) $display("mismatch at %0t: %s", $time, msg);
    endtask

    // work out the results of one accepted element and advance the counters
    task automatic predict_link_step(input logic signed [31:0] re, input logic signed [31:0] im,
                                     input bit use_known, input link_elem_t known);
        int    rows;
        int    dir;
        bit    end_row;
        bit    end_dir;
        bit    end_site;
        bit    end_x;
        bit    end_y;
        bit    end_z;
        bit    recon;
        cval_t cur;
        cval_t c;
        rows     = (rows_cfg == ROWS_FULL) ? 3 : 2;
        dir      = (dir_at + 1) % 4;
        end_row  = col_at >= 2;
        end_dir  = end_row && row_at >= rows - 1;
        end_site = end_dir && dir_at >= 3;
        end_x    = end_site && site_x >= span(ext_x_cfg) - 1;
        end_y    = end_x && site_y >= span(ext_y_cfg) - 1;
        end_z    = end_y && site_z >= span(ext_z_cfg) - 1;
        recon    = rows == 2 && end_dir;
        cur.re   = re;
        cur.im   = im;

        // keep the first two rows, less their last element
        if (row_at < 2 && col_at < 3 && row_at * 3 + col_at < 5)
            held_elems[row_at * 3 + col_at] = cur;

        if (use_known)
            due_elements.push_back(known);
        else
            due_elements.push_back(make_elem(cur.re, cur.im, row_at, col_at, 1'b0, !recon,
                                             !recon && end_z, dir));

        // rebuilt third row after the sixth element
        if (recon) begin
            c = conj_cross(held_elems[1], cur, held_elems[4], held_elems[2]);
            due_elements.push_back(make_elem(c.re, c.im, ROW_THIRD, 0, 1'b1, 1'b0, 1'b0, dir));
            c = conj_cross(held_elems[3], held_elems[2], held_elems[0], cur);
            due_elements.push_back(make_elem(c.re, c.im, ROW_THIRD, 1, 1'b1, 1'b0, 1'b0, dir));
            c = conj_cross(held_elems[0], held_elems[4], held_elems[3], held_elems[1]);
            due_elements.push_back(make_elem(c.re, c.im, ROW_THIRD, 2, 1'b1, 1'b1, end_z, dir));
        end

        // counters wrap at the end of their span, or beyond it after a change
        col_at = end_row ? 0 : col_at + 1;
        if (end_row) row_at = end_dir ? 0 : row_at + 1;
        if (end_dir) dir_at = end_site ? 0 : dir_at + 1;
        if (end_site) site_x = end_x ? 0 : site_x + 1;
        if (end_x) site_y = end_y ? 0 : site_y + 1;
        if (end_y) site_z = end_z ? 0 : site_z + 1;
    endtask

    // offer one element after a random gap and hold it until the transfer
    task automatic push_elem(input logic signed [31:0] re, input logic signed [31:0] im,
                             input bit use_known, input link_elem_t known);
        bit taken;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_elem_re  <= re;
        i_elem_im  <= im;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = o_in_ready;
            @(posedge i_clk);
        end
        predict_link_step(re, im, use_known, known);
    endtask

    // stop sending until every pending result has come out
    task automatic drain_results;
        i_in_valid <= 1'b0;
        while (due_elements.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // caller lowers the write enable after the last write
    task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_EXTENT_X:    ext_x_cfg = val;
            CFG_EXTENT_Y:    ext_y_cfg = val;
            CFG_EXTENT_Z:    ext_z_cfg = val;
            CFG_ROWS_STORED: rows_cfg  = val[1:0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] pick_value;
        if ($urandom_range(7) != 0) return $urandom;
        case ($urandom_range(4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'h4000_0000;
            default: return 32'hC000_0000;
        endcase
    endfunction

    // one random phase under a fresh setting, written while idle
    task automatic run_setting(input logic [6:0] ex, input logic [6:0] ey, input logic [6:0] ez,
                               input logic [1:0] rows, input int count, input int pause_at);
        drain_results();
        write_reg(CFG_EXTENT_X, ex);
        write_reg(CFG_EXTENT_Y, ey);
        write_reg(CFG_EXTENT_Z, ez);
        write_reg(CFG_ROWS_STORED, {5'd0, rows});
        i_cfg_we <= 1'b0;
        for (int k = 0; k < count; k++) begin
            if (k == pause_at) drain_results();
            push_elem(pick_value(), pick_value(), 1'b0, '0);
        end
    endtask

    task automatic add_elem(input logic [31:0] re, input logic [31:0] im);
        opening_row_t r;
        r        = '{default: '0};
        r.re     = re;
        r.im     = im;
        opening.push_back(r);
    endtask

    // element passed through at the origin site, its tags typed in
    task automatic add_known(input logic [31:0] re, input logic [31:0] im, input logic [1:0] dir,
                             input logic [1:0] row, input logic [1:0] col);
        opening_row_t r;
        r             = '{default: '0};
        r.re          = re;
        r.im          = im;
        r.known       = 1'b1;
        r.want        = '0;
        r.want.re     = re;
        r.want.im     = im;
        r.want.dir    = dir;
        r.want.row    = row;
        r.want.col    = col;
        r.want.lrun   = 1'b1;
        opening.push_back(r);
    endtask

    task automatic add_reg(input logic [1:0] idx, input logic [6:0] val);
        opening_row_t r;
        r         = '{default: '0};
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        opening.push_back(r);
    endtask

    // receiver stalls at random
    always @(posedge i_clk) begin
        i_out_ready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // inputs are stable at the falling edge, so a transfer seen here lands on the next rise
    always @(negedge i_clk) begin : check_results
        link_elem_t got;
        link_elem_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_out_re, o_out_im, o_site_x, o_site_y, o_site_z, o_direction, o_row, o_col,
                   o_reconstructed, o_last_of_run, o_last_of_slice};
            if (due_elements.size() == 0) begin
                flag_error($sformatf("unexpected transfer %s", show_elem(got)));
            end else begin
                want = due_elements.pop_front();
                if (got !== want)
                    flag_error($sformatf("expected %s got %s", show_elem(want), show_elem(got)));
            end
        end
    end

    // run limit
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        opening_row_t r;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_EXTENT_X;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_elem_re     = '0;
        i_elem_im     = '0;
        err_count     = 0;
        send_idle_pct = 28;
        recv_idle_pct = 87;
        ext_x_cfg     = EXTENT_RESET;
        ext_y_cfg     = EXTENT_RESET;
        ext_z_cfg     = EXTENT_RESET;
        rows_cfg      = ROWS_RESET;
        col_at        = 0;
        row_at        = 0;
        dir_at        = 0;
        site_x        = 0;
        site_y        = 0;
        site_z        = 0;
        foreach (held_elems[i]) held_elems[i] = '{re: 0, im: 0};

        // first direction: extremes, the rebuilt row saturates
        add_known(32'h7FFF_FFFF, 32'h8000_0000, 2'd1, 2'd0, 2'd0);
        add_elem(32'h8000_0000, 32'h7FFF_FFFF);
        add_elem(32'h8000_0000, 32'h0000_0000);
        add_elem(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_elem(32'h8000_0000, 32'h8000_0000);
        add_elem(32'h8000_0000, 32'h7FFF_FFFF);
        // second direction: two unit rows give a unit third row
        add_elem(32'h4000_0000, 32'h0000_0000);
        add_elem(32'h0000_0000, 32'h0000_0000);
        add_elem(32'h0000_0000, 32'h0000_0000);
        add_elem(32'h0000_0000, 32'h0000_0000);
        add_elem(32'h4000_0000, 32'h0000_0000);
        add_elem(32'h0000_0000, 32'h0000_0000);
        // third direction, switched to three stored rows part way through
        add_known(32'hFFFF_FFFF, 32'h0000_0001, 2'd3, 2'd0, 2'd0);
        add_elem(32'h1234_5678, 32'hEDCB_A987);
        add_reg(CFG_ROWS_STORED, {5'd0, ROWS_FULL});
        add_elem(32'h0000_0001, 32'hFFFF_FFFF);
        add_elem(32'h3FFF_FFFF, 32'hC000_0000);
        add_elem(32'hC000_0001, 32'h4000_0000);
        add_elem(32'h7FFF_FFFF, 32'h0000_0000);
        add_elem(32'h2AAA_AAAA, 32'hD555_5556);
        add_elem(32'h0F0F_0F0F, 32'hF0F0_F0F0);
        add_known(32'h5555_5555, 32'hAAAA_AAAA, 2'd3, 2'd2, 2'd2);
        // file direction four maps to zero; a rows value below two rebuilds
        add_reg(CFG_ROWS_STORED, 7'd0);
        add_known(32'h0000_0000, 32'hFFFF_FFFF, 2'd0, 2'd0, 2'd0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // opening table
        foreach (opening[i]) begin
            r = opening[i];
            if (r.is_reg) begin
                drain_results();
                write_reg(r.reg_idx, r.reg_val);
                i_cfg_we <= 1'b0;
            end else begin
                push_elem(r.re, r.im, r.known, r.want);
            end
        end

        // random phases: small slices to reach slice ends, extent extremes, mid-slice changes
        run_setting(7'd1, 7'd1, 7'd1, ROWS_RESET, 40, -1);
        run_setting(7'd0, 7'd127, 7'd1, ROWS_FULL, 40, -1);
        send_idle_pct = 87;
        recv_idle_pct = 28;
        run_setting(7'd2, 7'd1, 7'd1, 2'd1, 40, 20);
        run_setting(7'd64, 7'd64, 7'd64, ROWS_FULL, 60, -1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_setting(7'd1, 7'd2, 7'd1, ROWS_RESET, 40, -1);

        drain_results();
        repeat (8) @(posedge i_clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
